// ----- rtl/trmb_pkg.sv -----
// ----------------------------------------------------------------------------
// Tab-marked record builder package
// Shared constants, action codes and the read request bundle.
// ----------------------------------------------------------------------------
package trmb_pkg;

  localparam int RECORD_MAX_DEF = 256;
  localparam int COL_W          = 16;
  localparam int LEN_W          = 9;
  localparam int CHAR_W         = 8;
  localparam int S_TDATA_W      = 24;
  localparam int M_TDATA_W      = 24;

  localparam logic [LEN_W-1:0]  RECORD_LEN_RST = 9'd80;
  localparam logic [COL_W-1:0]  COL_SAT        = 16'hFFFF;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_FEED  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_OPEN    = 8'h01;
  localparam logic [CHAR_W-1:0] CHAR_CLOSE   = 8'h02;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] KIND_L       = 8'h4C;
  localparam logic [CHAR_W-1:0] KIND_R       = 8'h52;
  localparam logic [CHAR_W-1:0] KIND_T       = 8'h54;

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [COL_W-1:0] column;
  } rd_req_t;

endpackage

// ----- rtl/trmb_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module trmb_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AddrW-1:0]  wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AddrW-1:0]  rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/trmb_engine.sv -----
// ----------------------------------------------------------------------------
// Record builder engine
// Input register, column and marker tracking, column flags and store writes.
// ----------------------------------------------------------------------------
module trmb_engine #(
  parameter int RECORD_MAX = trmb_pkg::RECORD_MAX_DEF,
  localparam int AddrW = (RECORD_MAX > 1) ? $clog2(RECORD_MAX) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [trmb_pkg::LEN_W-1:0]      cfg_wr_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [trmb_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                            rd_ready,
  output trmb_pkg::rd_req_t               rd_req,
  output logic                            ram_wr_en,
  output logic [AddrW-1:0]                ram_wr_addr,
  output logic [trmb_pkg::CHAR_W-1:0]     ram_wr_data,
  output logic [AddrW-1:0]                ram_rd_addr
);

  import trmb_pkg::*;

  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_KIND   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  logic                  s1_valid;
  logic [1:0]            s1_action;
  logic [CHAR_W-1:0]     s1_byte;
  logic [CHAR_W-1:0]     s1_rc;
  logic                  s1_adv;
  logic                  do_item;

  logic [LEN_W-1:0]      record_length;
  logic [COL_W-1:0]      column, column_next;
  logic [1:0]            phase, phase_next;
  logic [CHAR_W-1:0]     marker_kind, marker_kind_next;
  logic [COL_W-1:0]      marker_value, marker_value_next;
  logic [RECORD_MAX-1:0] written, written_next;
  logic [RECORD_MAX-1:0] nonspace, nonspace_next;

  logic [COL_W:0]        eff_len;
  logic                  col_in;
  logic                  rc_in;
  logic [AddrW-1:0]      wr_idx;
  logic [AddrW-1:0]      rd_idx;
  logic                  is_digit;
  logic [COL_W+3:0]      value_x10;
  logic [COL_W-1:0]      moved_column;

  function automatic logic [COL_W-1:0] marker_move(input logic [CHAR_W-1:0] kind,
                                                   input logic [COL_W-1:0] value,
                                                   input logic [COL_W-1:0] col);
    logic [COL_W:0] sum;
    sum = {1'b0, col} + {1'b0, value};
    marker_move = col;
    if (kind == KIND_T) begin
      marker_move = (value != '0) ? value - COL_W'(1) : '0;
    end else if (kind == KIND_R) begin
      marker_move = sum[COL_W] ? COL_SAT : sum[COL_W-1:0];
    end else if (kind == KIND_L) begin
      marker_move = (col > value) ? col - value : '0;
    end
  endfunction

  assign s1_adv   = !s1_valid || (s1_action != ACT_READ) || rd_ready;
  assign s_tready = !s1_valid || s1_adv;
  assign do_item  = s1_valid && s1_adv;

  assign eff_len  = ((COL_W+1)'(record_length) < (COL_W+1)'(RECORD_MAX)) ?
                    (COL_W+1)'(record_length) : (COL_W+1)'(RECORD_MAX);
  assign col_in   = {1'b0, column} < eff_len;
  assign rc_in    = (COL_W+1)'(s1_rc) < eff_len;
  assign wr_idx   = column[AddrW-1:0];
  assign rd_idx   = AddrW'(s1_rc);
  assign is_digit = (s1_byte >= CHAR_ZERO) && (s1_byte <= CHAR_NINE);
  assign value_x10 = {1'b0, marker_value, 3'b000} + {3'b000, marker_value, 1'b0}
                     + (COL_W+4)'(s1_byte - CHAR_ZERO);
  assign moved_column = marker_move(marker_kind, marker_value, column);

  assign ram_wr_data = s1_byte;
  assign ram_rd_addr = rd_idx;

  always_comb begin
    column_next       = column;
    phase_next        = phase;
    marker_kind_next  = marker_kind;
    marker_value_next = marker_value;
    written_next      = written;
    nonspace_next     = nonspace;
    ram_wr_en         = 1'b0;
    ram_wr_addr       = wr_idx;
    rd_req.valid      = 1'b0;
    rd_req.hit        = rc_in && written[rd_idx];
    rd_req.column     = column;
    if (do_item) begin
      case (s1_action)
        ACT_START: begin
          column_next       = '0;
          phase_next        = PH_NORMAL;
          marker_kind_next  = '0;
          marker_value_next = '0;
          written_next      = '0;
          nonspace_next     = '0;
        end
        ACT_FEED: begin
          case (phase)
            PH_NORMAL: begin
              if (s1_byte == CHAR_NUL || s1_byte == CHAR_NEWLINE) begin
                phase_next = PH_DONE;
              end else if (s1_byte == CHAR_OPEN) begin
                phase_next = PH_KIND;
              end else begin
                if (col_in && (s1_byte != CHAR_SPACE || !nonspace[wr_idx])) begin
                  ram_wr_en             = 1'b1;
                  written_next[wr_idx]  = 1'b1;
                  nonspace_next[wr_idx] = (s1_byte != CHAR_SPACE);
                end
                if (column != COL_SAT) begin
                  column_next = column + COL_W'(1);
                end
              end
            end
            PH_KIND: begin
              if (s1_byte == CHAR_NUL) begin
                phase_next = PH_DONE;
              end else begin
                marker_kind_next  = s1_byte;
                marker_value_next = '0;
                phase_next        = PH_DIGITS;
              end
            end
            PH_DIGITS: begin
              if (s1_byte == CHAR_CLOSE) begin
                column_next = moved_column;
                phase_next  = PH_NORMAL;
              end else if (s1_byte == CHAR_NUL) begin
                column_next = moved_column;
                phase_next  = PH_DONE;
              end else if (is_digit) begin
                marker_value_next = (value_x10 > (COL_W+4)'(COL_SAT)) ?
                                    COL_SAT : value_x10[COL_W-1:0];
              end
            end
            default: begin
            end
          endcase
        end
        ACT_READ: begin
          rd_req.valid = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      record_length <= RECORD_LEN_RST;
      column        <= '0;
      phase         <= PH_NORMAL;
      marker_kind   <= '0;
      marker_value  <= '0;
      written       <= '0;
      nonspace      <= '0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (cfg_wr_en) begin
        record_length <= cfg_wr_data;
      end
      column       <= column_next;
      phase        <= phase_next;
      marker_kind  <= marker_kind_next;
      marker_value <= marker_value_next;
      written      <= written_next;
      nonspace     <= nonspace_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_action <= s_tdata[1:0];
      s1_byte   <= s_tdata[9:2];
      s1_rc     <= s_tdata[17:10];
    end
  end

endmodule

// ----- rtl/tab_marked_record_builder.sv -----
// ----------------------------------------------------------------------------
// Tab-marked record builder
// Builds a fixed-length text record from a byte stream with in-band tab markers.
// ----------------------------------------------------------------------------
// The block takes one input beat in every clock cycle, whatever its action, and
// keeps doing so while a read result waits at the output; input ready drops only
// when three read results are held inside and the output is stalled. A read
// result passes from the input register through the registered read of the
// record store to the output register, and waits in each while the next is
// stalled. The record store is a RECORD_MAX-entry memory (256 by default) without
// reset; per-column flags in flip-flops mark written columns, so a start beat
// clears the record by clearing the flags and no clearing pass follows reset.
module tab_marked_record_builder #(
  parameter int RECORD_MAX = trmb_pkg::RECORD_MAX_DEF,
  localparam int AddrW = (RECORD_MAX > 1) ? $clog2(RECORD_MAX) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [trmb_pkg::LEN_W-1:0]      cfg_wr_data,  // record_length
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [trmb_pkg::S_TDATA_W-1:0]  s_tdata,      // action, data_byte, read_column
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [trmb_pkg::M_TDATA_W-1:0]  m_tdata       // read_char, current_column
);

  import trmb_pkg::*;

  rd_req_t           rd_req;
  logic              rd_ready;
  logic              ram_wr_en;
  logic [AddrW-1:0]  ram_wr_addr;
  logic [CHAR_W-1:0] ram_wr_data;
  logic [AddrW-1:0]  ram_rd_addr;
  logic [CHAR_W-1:0] ram_rd_data;

  logic              s2_valid;
  logic              s2_hit;
  logic [COL_W-1:0]  s2_column;
  logic              s2_move;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic [COL_W-1:0]  out_column;

  trmb_engine #(
    .RECORD_MAX(RECORD_MAX)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .rd_ready   (rd_ready),
    .rd_req     (rd_req),
    .ram_wr_en  (ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data),
    .ram_rd_addr(ram_rd_addr)
  );

  trmb_ram #(
    .DATA_W(CHAR_W),
    .DEPTH (RECORD_MAX)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (rd_req.valid),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  assign s2_move  = s2_valid && (!out_valid || m_tready);
  assign rd_ready = !s2_valid || s2_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rd_ready) begin
        s2_valid <= rd_req.valid;
      end
      if (!out_valid || m_tready) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_ready && rd_req.valid) begin
      s2_hit    <= rd_req.hit;
      s2_column <= rd_req.column;
    end
    if (s2_move) begin
      out_char   <= s2_hit ? ram_rd_data : CHAR_SPACE;
      out_column <= s2_column;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_column, out_char};

endmodule

// ----- rtl/trmb_check.sv -----
// ----------------------------------------------------------------------------
// Record builder port checker
// Watches the stream ports of the record builder and flags ordering slips.
// ----------------------------------------------------------------------------
module trmb_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [trmb_pkg::S_TDATA_W-1:0] s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [trmb_pkg::M_TDATA_W-1:0] m_tdata
);

  import trmb_pkg::*;

  logic [2:0] pending;
  logic       read_in;
  logic       beat_out;

  assign read_in  = s_tvalid && s_tready && (s_tdata[1:0] == ACT_READ);
  assign beat_out = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(read_in) - 3'(beat_out);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 3'd0)
    else $error("output beat without an outstanding read");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd3)
    else $error("more reads outstanding than the pipeline holds");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled while the output is empty");

endmodule

bind tab_marked_record_builder trmb_check u_check (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
